// File: rtl/pwci_pkg.sv
// Package for the conditional-integration PID block: state and command types,
// register indexes, reset values and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package pwci_pkg;

  // configuration register file
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_ERR_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT    = 3'd6;

  localparam logic [CFG_DATA_W-1:0] RST_GAIN_P          = 31'd144179;
  localparam logic [CFG_DATA_W-1:0] RST_GAIN_I          = 31'd104858;
  localparam logic [CFG_DATA_W-1:0] RST_GAIN_D          = 31'd721;
  localparam logic [CFG_DATA_W-1:0] RST_ERROR_LIMIT     = 31'd65536000;
  localparam logic [CFG_DATA_W-1:0] RST_INTEGRAL_LIMIT  = 31'd2621440;
  localparam logic [CFG_DATA_W-1:0] RST_INTEG_ERR_LIMIT = 31'd65536000;
  localparam logic [CFG_DATA_W-1:0] RST_OUTPUT_LIMIT    = 31'd13107200;

  // field widths
  localparam int DATA_W = 32;
  localparam int DT_W   = 20;

  // divider: |num| << 16 over dt, two quotient bits per cycle
  localparam int QUO_W      = 48;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
  localparam int DIV_CNT_W  = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_E,
    ST_INC,
    ST_DIV,
    ST_SUM,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_E
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     load_in;
    logic     cap_p;
    logic     cap_i;
    logic     div_load;
    logic     cap_inc;
    logic     div_step;
    logic     cap_sum;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/pwci_ctrl.sv
// Sequencer for the PID block: walks one item through the shared multiplier,
// the divider and the final update. Depends on pwci_pkg.
`timescale 1ns / 1ps

module pwci_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output pwci_pkg::cmd_t    cmd,
  input  pwci_pkg::status_t status
);

  pwci_pkg::state_t state_r, state_nxt;
  logic [pwci_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwci_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.mul_sel = pwci_pkg::MUL_P;
    unique case (state_r)
      pwci_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = pwci_pkg::ST_MUL_P;
        end
      end
      pwci_pkg::ST_MUL_P: begin
        cmd.mul_sel = pwci_pkg::MUL_P;
        state_nxt   = pwci_pkg::ST_MUL_I;
      end
      pwci_pkg::ST_MUL_I: begin
        cmd.mul_sel = pwci_pkg::MUL_I;
        cmd.cap_p   = 1'b1;
        state_nxt   = pwci_pkg::ST_MUL_D;
      end
      pwci_pkg::ST_MUL_D: begin
        cmd.mul_sel = pwci_pkg::MUL_D;
        cmd.cap_i   = 1'b1;
        state_nxt   = pwci_pkg::ST_MUL_E;
      end
      pwci_pkg::ST_MUL_E: begin
        cmd.mul_sel  = pwci_pkg::MUL_E;
        cmd.div_load = 1'b1;
        state_nxt    = pwci_pkg::ST_INC;
      end
      pwci_pkg::ST_INC: begin
        cmd.cap_inc = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = pwci_pkg::ST_DIV;
      end
      pwci_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == pwci_pkg::DIV_CNT_W'(pwci_pkg::DIV_CYCLES - 1)) begin
          state_nxt = pwci_pkg::ST_SUM;
        end
      end
      pwci_pkg::ST_SUM: begin
        cmd.cap_sum = 1'b1;
        state_nxt   = pwci_pkg::ST_FIN;
      end
      pwci_pkg::ST_FIN: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = pwci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pwci_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pwci_dp.sv
// Datapath for the PID block: config registers, shared 33x33 multiplier,
// radix-4 restoring divider, integral/error state and the output register.
// Depends on pwci_pkg.
`timescale 1ns / 1ps

module pwci_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pwci_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pwci_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [pwci_pkg::DATA_W-1:0]   in_error_in,
  input  logic [pwci_pkg::DT_W-1:0]            in_time_step,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pwci_pkg::DATA_W-1:0]   out_drive,
  output logic                                 out_drive_clamped,
  input  pwci_pkg::cmd_t                       cmd,
  output pwci_pkg::status_t                    status
);

  localparam int DW = pwci_pkg::DATA_W;
  localparam int CW = pwci_pkg::CFG_DATA_W;
  localparam int TW = pwci_pkg::DT_W;
  localparam int QW = pwci_pkg::QUO_W;

  // configuration
  logic [CW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [CW-1:0] err_lim_r, int_lim_r, int_err_lim_r, out_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= pwci_pkg::RST_GAIN_P;
      gain_i_r      <= pwci_pkg::RST_GAIN_I;
      gain_d_r      <= pwci_pkg::RST_GAIN_D;
      err_lim_r     <= pwci_pkg::RST_ERROR_LIMIT;
      int_lim_r     <= pwci_pkg::RST_INTEGRAL_LIMIT;
      int_err_lim_r <= pwci_pkg::RST_INTEG_ERR_LIMIT;
      out_lim_r     <= pwci_pkg::RST_OUTPUT_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pwci_pkg::REG_GAIN_P:          gain_p_r      <= cfg_data;
        pwci_pkg::REG_GAIN_I:          gain_i_r      <= cfg_data;
        pwci_pkg::REG_GAIN_D:          gain_d_r      <= cfg_data;
        pwci_pkg::REG_ERROR_LIMIT:     err_lim_r     <= cfg_data;
        pwci_pkg::REG_INTEGRAL_LIMIT:  int_lim_r     <= cfg_data;
        pwci_pkg::REG_INTEG_ERR_LIMIT: int_err_lim_r <= cfg_data;
        pwci_pkg::REG_OUTPUT_LIMIT:    out_lim_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture: error clamped on the way in, zero dt taken as one LSB
  logic signed [DW:0] err_ext, err_lim_ext;
  logic signed [DW-1:0] err_clamped;
  logic signed [DW-1:0] e_r, prev_r, integ_r;
  logic [TW-1:0] dt_r;

  always_comb begin
    err_ext     = {in_error_in[DW-1], in_error_in};
    err_lim_ext = {2'b00, err_lim_r};
    if (err_ext > err_lim_ext) begin
      err_clamped = err_lim_ext[DW-1:0];
    end else if (err_ext < -err_lim_ext) begin
      err_clamped = DW'(-err_lim_ext);
    end else begin
      err_clamped = in_error_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      e_r  <= err_clamped;
      dt_r <= (in_time_step == '0) ? TW'(1) : in_time_step;
    end
  end

  // saturated e - previous error
  logic signed [DW:0] diff_wide;
  logic signed [DW-1:0] diff;
  assign diff_wide = {e_r[DW-1], e_r} - {prev_r[DW-1], prev_r};
  assign diff = pwci_pkg::sat32(64'(diff_wide));

  // shared multiplier, product registered every cycle
  logic signed [DW:0] mul_a, mul_b;
  logic signed [2*DW+1:0] prod_r;
  logic signed [63:0] post64;
  logic signed [DW-1:0] post_sat;

  always_comb begin
    case (cmd.mul_sel)
      pwci_pkg::MUL_P: begin
        mul_a = {2'b00, gain_p_r};
        mul_b = {e_r[DW-1], e_r};
      end
      pwci_pkg::MUL_I: begin
        mul_a = {2'b00, gain_i_r};
        mul_b = {integ_r[DW-1], integ_r};
      end
      pwci_pkg::MUL_D: begin
        mul_a = {2'b00, gain_d_r};
        mul_b = {diff[DW-1], diff};
      end
      default: begin
        mul_a = {e_r[DW-1], e_r};
        mul_b = {(DW + 1 - TW)'(0), dt_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // floor shift by 16 is the upper bits, sign-extended; then saturate
  assign post64   = 64'($signed(prod_r[2*DW+1:16]));
  assign post_sat = pwci_pkg::sat32(post64);

  logic signed [DW-1:0] p_r, i_r, inc_r, sum_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_p) begin
      p_r <= post_sat;
    end
    if (cmd.cap_i) begin
      i_r <= post_sat;
    end
    if (cmd.cap_inc) begin
      inc_r <= post_sat;
    end
  end

  // divider on magnitudes, sign restored afterwards (truncates toward zero)
  logic [TW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic neg_r;
  logic [DW-1:0] num_mag;

  assign num_mag = post_sat[DW-1] ? (~post_sat + 1'b1) : post_sat;

  always_comb begin
    logic [TW:0] rem_sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < pwci_pkg::DIV_STEPS; k++) begin
      rem_sh = {rem_nxt, quo_nxt[QW-1]};
      if (rem_sh >= {1'b0, dt_r}) begin
        rem_sh  = rem_sh - {1'b0, dt_r};
        quo_nxt = {quo_nxt[QW-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      end
      rem_nxt = rem_sh[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= post_sat[DW-1];
      quo_r <= {num_mag, (QW - DW)'(0)};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // derivative term and saturated sum
  logic signed [DW-1:0] d_term;
  logic signed [DW+1:0] pid_sum;

  always_comb begin
    if (!neg_r) begin
      d_term = (quo_r > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_r[DW-1:0];
    end else begin
      d_term = (quo_r > QW'(32'h8000_0000)) ? 32'sh8000_0000 : -quo_r[DW-1:0];
    end
    pid_sum = (DW + 2)'(p_r) + (DW + 2)'(i_r) + (DW + 2)'(d_term);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_sum) begin
      sum_r <= pwci_pkg::sat32(64'(pid_sum));
    end
  end

  // integral update and output clamp
  logic [DW:0] e_mag, sum_mag;
  logic integ_en;
  logic signed [DW+1:0] integ_sum, int_lim_ext;
  logic signed [DW-1:0] integ_new;
  logic signed [DW:0] sum_ext, out_lim_ext;
  logic signed [DW-1:0] drive_new;
  logic hit;

  always_comb begin
    e_mag   = e_r[DW-1] ? ((DW + 1)'(0) - {e_r[DW-1], e_r}) : {1'b0, e_r};
    sum_mag = sum_r[DW-1] ? ((DW + 1)'(0) - {sum_r[DW-1], sum_r}) : {1'b0, sum_r};
    integ_en = (e_mag < {2'b00, int_err_lim_r}) && (sum_mag < {2'b00, out_lim_r});

    integ_sum = (DW + 2)'(integ_r) + (integ_en ? (DW + 2)'(inc_r) : '0);
    int_lim_ext = {3'b000, int_lim_r};
    if (integ_sum > int_lim_ext) begin
      integ_new = int_lim_ext[DW-1:0];
    end else if (integ_sum < -int_lim_ext) begin
      integ_new = DW'(-int_lim_ext);
    end else begin
      integ_new = integ_sum[DW-1:0];
    end

    sum_ext     = {sum_r[DW-1], sum_r};
    out_lim_ext = {2'b00, out_lim_r};
    hit         = 1'b0;
    drive_new   = sum_r;
    if (sum_ext > out_lim_ext) begin
      drive_new = out_lim_ext[DW-1:0];
      hit       = 1'b1;
    end else if (sum_ext < -out_lim_ext) begin
      drive_new = DW'(-out_lim_ext);
      hit       = 1'b1;
    end
  end

  logic out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] drive_r;
  logic clamped_r;

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      integ_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.finish) begin
        prev_r  <= e_r;
        integ_r <= integ_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      drive_r   <= drive_new;
      clamped_r <= hit;
    end
  end

  assign status.out_free   = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_drive         = drive_r;
  assign out_drive_clamped = clamped_r;

endmodule

// File: rtl/pid_with_conditional_integration.sv
// PID controller with conditional integration, Q16.16. Each item (error, dt)
// gives one result (drive, drive_clamped) after it is accepted: four passes
// through one shared 33x33 multiplier, a two-bit-per-cycle divider for the
// derivative quotient, then the sum and state update. A new item is taken once
// the previous one has left the datapath, even while its result still waits in
// the output register; the last step stalls only while an earlier result is
// still held in the output register. Configuration writes go straight into
// their registers.
// Top level: instantiates pwci_ctrl and pwci_dp; depends on pwci_pkg.
`timescale 1ns / 1ps

module pid_with_conditional_integration (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pwci_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwci_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pwci_pkg::DATA_W-1:0] in_error_in,
  input  logic [pwci_pkg::DT_W-1:0]          in_time_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pwci_pkg::DATA_W-1:0] out_drive,
  output logic                               out_drive_clamped
);

  pwci_pkg::cmd_t    cmd;
  pwci_pkg::status_t status;

  pwci_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pwci_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_error_in       (in_error_in),
    .in_time_step      (in_time_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive         (out_drive),
    .out_drive_clamped (out_drive_clamped),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// File: dv/pid_with_conditional_integration_test.sv
// Testbench for pid_with_conditional_integration: drives (error, dt) items,
// predicts drive and drive_clamped in a scoreboard class and checks every result.
// Depends on pwci_pkg and the pid_with_conditional_integration RTL.
`timescale 1ns / 1ps

module pid_with_conditional_integration_test;
  import pwci_pkg::*;

  localparam int unsigned RUN_LIMIT = 600000;
  localparam int PHASE_ITEMS = 130;
  localparam int NUM_PHASES = 10;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_DATA_W-1:0] REG_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } drive_t;

  // Predicts the controller output and keeps the drives still owed by the block.
  class drive_scoreboard;
    longint gain_p, gain_i, gain_d;
    longint err_lim, integ_lim, integ_err_lim, out_lim;
    longint last_err, integ;
    drive_t owed[$];
    int mismatches;

    function new();
      gain_p = RST_GAIN_P;
      gain_i = RST_GAIN_I;
      gain_d = RST_GAIN_D;
      err_lim = RST_ERROR_LIMIT;
      integ_lim = RST_INTEGRAL_LIMIT;
      integ_err_lim = RST_INTEG_ERR_LIMIT;
      out_lim = RST_OUTPUT_LIMIT;
      last_err = 0;
      integ = 0;
      mismatches = 0;
    endfunction

    static function longint clip32(longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
    endfunction

    static function longint abs64(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_GAIN_P:          gain_p = val;
        REG_GAIN_I:          gain_i = val;
        REG_GAIN_D:          gain_d = val;
        REG_ERROR_LIMIT:     err_lim = val;
        REG_INTEGRAL_LIMIT:  integ_lim = val;
        REG_INTEG_ERR_LIMIT: integ_err_lim = val;
        REG_OUTPUT_LIMIT:    out_lim = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] err, logic [DT_W-1:0] step);
      longint e, dt, p, i, d, diff, num, drv, acc;
      drive_t x;
      e = err;
      dt = step;
      if (dt == 0) dt = 1;
      if (e > err_lim) e = err_lim;
      else if (e < -err_lim) e = -err_lim;
      // arithmetic shift of a signed longint rounds toward minus infinity
      p = clip32((gain_p * e) >>> 16);
      i = clip32((gain_i * integ) >>> 16);
      diff = clip32(e - last_err);
      num = clip32((gain_d * diff) >>> 16);
      d = clip32((num * 65536) / dt);
      drv = clip32(p + i + d);
      // integration uses the unclamped drive
      acc = integ;
      if (abs64(e) < integ_err_lim && abs64(drv) < out_lim)
        acc += clip32((e * dt) >>> 16);
      if (acc > integ_lim) acc = integ_lim;
      else if (acc < -integ_lim) acc = -integ_lim;
      integ = acc;
      x.clamped = (drv > out_lim) || (drv < -out_lim);
      if (drv > out_lim) drv = out_lim;
      else if (drv < -out_lim) drv = -out_lim;
      last_err = e;
      x.drive = drv[31:0];
      owed.push_back(x);
    endfunction

    function void check_drive(logic signed [DATA_W-1:0] drive, logic clamped);
      drive_t x;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("drive %0d clamped %0b with no item outstanding", drive, clamped);
      end else begin
        x = owed.pop_front();
        if (x.drive !== drive || x.clamped !== clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch: expected %0d clamped %0b, got %0d clamped %0b",
                     x.drive, x.clamped, drive, clamped);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] in_error_in = '0;
  logic [DT_W-1:0] in_time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_drive;
  logic out_drive_clamped;

  drive_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  logic holding = 1'b0;
  int unsigned cycle_count = 0;
  longint walk_err = 0;

  pid_with_conditional_integration dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_error_in      (in_error_in),
    .in_time_step     (in_time_step),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive        (out_drive),
    .out_drive_clamped(out_drive_clamped)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: check accepted items, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_drive(out_drive, out_drive_clamped);
      out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, so the block backs up into its input
  initial begin : long_hold
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_req != served) begin
        served = hold_req;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          holding <= 1'b1;
          @(posedge clk);
        end
        holding <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] err,
                             input logic [DT_W-1:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_error_in <= err;
    in_time_step <= step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(err, step);
  endtask

  // called in the step of the last acceptance, so valid drops before the next edge
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // leaves the enable high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] gp, gi, gd,
                                input logic [CFG_DATA_W-1:0] el, il, iel, ol);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_ERROR_LIMIT, el);
    write_reg(REG_INTEGRAL_LIMIT, il);
    write_reg(REG_INTEG_ERR_LIMIT, iel);
    write_reg(REG_OUTPUT_LIMIT, ol);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_reg();
    case ($urandom_range(4))
      0: return '0;
      1: return REG_MAX;
      2: return 31'($urandom_range(0, 1 << 20));
      3: return 31'($urandom_range(0, 100 << 16));
      default: return 31'($urandom);
    endcase
  endfunction

  // mostly a slowly moving error so the integrator and derivative see real signals
  function automatic logic signed [DATA_W-1:0] pick_error();
    longint v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = walk_err + (int'($urandom_range(0, 1 << 19)) - (1 << 18));
      5, 6: v = int'($urandom);
      7: begin
        case ($urandom_range(4))
          0: v = -64'sh8000_0000;
          1: v = 64'sh7FFF_FFFF;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = sb.err_lim + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    v = drive_scoreboard::clip32(v);
    walk_err = v;
    return v[31:0];
  endfunction

  function automatic logic [DT_W-1:0] pick_step();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(2))
          0: return '0;
          1: return 20'd1;
          default: return 20'hF_FFFF;
        endcase
      end
      1, 2: return 20'($urandom_range(0, 20'hF_FFFF));
      default: return 20'($urandom_range(1 << 12, 1 << 17));
    endcase
  endfunction

  task automatic run_directed();
    send_sample(32'sd0, 20'h1_0000);
    send_sample(32'sh7FFF_FFFF, 20'h1_0000);
    send_sample(32'sh8000_0000, 20'h1_0000);
    send_sample(32'sd1, 20'd1);
    send_sample(-32'sd1, 20'd0);
    send_sample(32'sd327680, 20'd0);
    send_sample(-32'sd327680, 20'hF_FFFF);
    send_sample(32'sh7FFF_FFFF, 20'hF_FFFF);
    send_sample(32'sh8000_0000, 20'd1);
    send_sample(32'sd0, 20'd1);
    // steady error drives the integral into its limit
    repeat (6) send_sample(32'sd655360, 20'h4_0000);
    send_sample(-32'sd655360, 20'h4_0000);
    send_sample(32'sd655360, 20'h4_0000);
    drain();
    // lower the integral limit below the held integral with integration paused
    write_reg(REG_INTEGRAL_LIMIT, 31'd65536);
    write_reg(REG_INTEG_ERR_LIMIT, 31'd0);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_sample(32'sd65536, 20'h1_0000);
    send_sample(32'sd65536, 20'h1_0000);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_settings(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_ERROR_LIMIT,
                          RST_INTEGRAL_LIMIT, RST_INTEG_ERR_LIMIT, RST_OUTPUT_LIMIT);
        1: apply_settings(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        2: apply_settings('0, '0, '0, '0, '0, '0, '0);
        3: apply_settings(REG_MAX, REG_MAX, REG_MAX, rand_reg(), rand_reg(), rand_reg(),
                          rand_reg());
        4: apply_settings(31'd16384, 31'd4096, 31'd0, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        default: apply_settings(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                                rand_reg(), rand_reg());
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      if (ph == 0 || ph == 5) hold_req <= hold_req + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_error(), pick_step());
      drain();
    end
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pwci_pkg.sv
rtl/pwci_ctrl.sv
rtl/pwci_dp.sv
rtl/pid_with_conditional_integration.sv
dv/pid_with_conditional_integration_test.sv
